// ===== src/ptsr_pkg.sv =====
// ptsr_pkg: shared types and constants for the priority task scheduler
// holds the sequencer state type, mode codes and fixed field widths
// no dependencies
`timescale 1ns / 1ps

package ptsr_pkg;

    // field widths fixed by the item layout
    localparam int MODE_W     = 3;
    localparam int ID_W       = 3;
    localparam int VAL_W      = 16;
    localparam int CD_W       = 32;
    localparam int BYTE_W     = 8;
    localparam int ID_EXT_W   = 6;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    // initial nearest wake time of a schedule pass
    localparam logic signed [CD_W-1:0] WAKE_LIMIT = 32'sd60000;
    localparam logic signed [CD_W-1:0] CD_MIN     = {1'b1, {(CD_W-1){1'b0}}};

    // item kinds carried on the input tuser
    localparam logic [MODE_W-1:0] MODE_SET_EVENT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET_RESERVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET_LATENCY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_TICKS   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SYNC        = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SCHEDULE    = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AGE,
        ST_CHECK,
        ST_FINISH,
        ST_OUT
    } t_state;

endpackage

// ===== src/priority_task_scheduler_with_reservation.sv =====
// priority_task_scheduler_with_reservation: prioritised task table with runtime reservation
// one shared subtract unit walked over the task table by a small sequencer
// depends on ptsr_pkg
`timescale 1ns / 1ps

// channel   | direction | signals                          | contents
// ----------+-----------+----------------------------------+-----------------------------------
// input     | in        | s_axis_tvalid/tready/tdata/tuser | one write or schedule request beat
// result    | out       | m_axis_tvalid/tready/tdata/tuser | one result beat per input beat
//
// a write beat passes accept, then the result register
// a schedule beat passes accept, the ageing walk over all NUM_TASKS entries, the takeover
// walk, finish and the result register; the takeover walk visits no entry when nothing is
// due or task 0 is due, else the entries up to the first taker, or all entries below the
// selected task when none takes over; the ageing walk visits one task a cycle through the
// shared subtractor, the takeover walk one task a cycle through the reserve compare
// i_rst_n (synchronous, active low) clears the whole task table and the sequencer
// s_axis_tready is high only while idle; a stalled result holds the block until taken

module priority_task_scheduler_with_reservation #(
    parameter int NUM_TASKS  = 8,
    parameter int TICK_SHIFT = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // task_id[2:0], value[18:3], elapsed[34:19], overhead[50:35], zero pad above
    input  logic [ptsr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode[2:0]
    input  logic [ptsr_pkg::MODE_W-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // selected_task[2:0], none_pending[3], wake_time[19:4], zero pad above
    output logic [ptsr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // is_schedule[0]
    output logic                                 m_axis_tuser
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int CD_W  = ptsr_pkg::CD_W;

    // task table, small enough for flip-flops with one walked read index
    logic [ptsr_pkg::BYTE_W-1:0] r_event   [NUM_TASKS];
    logic [ptsr_pkg::BYTE_W-1:0] r_reserve [NUM_TASKS];
    logic [ptsr_pkg::BYTE_W-1:0] r_latency [NUM_TASKS];
    logic signed [CD_W-1:0]      r_cd      [NUM_TASKS];

    ptsr_pkg::t_state r_state, n_state;

    // walk state of the current pass
    logic [CNT_W-1:0]            r_idx;
    logic [IDX_W-1:0]            r_sel;
    logic                        r_found;
    logic [ptsr_pkg::BYTE_W-1:0] r_res;
    logic signed [CD_W-1:0]      r_near;
    logic [ptsr_pkg::VAL_W-1:0]  r_elap;
    logic [ptsr_pkg::VAL_W-1:0]  r_ovh;

    // result register
    logic                        r_out_sched;
    logic [ptsr_pkg::ID_W-1:0]   r_out_sel;
    logic                        r_out_np;
    logic [ptsr_pkg::VAL_W-1:0]  r_out_wake;

    // input beat unpacking
    logic [ptsr_pkg::MODE_W-1:0]   w_mode;
    logic [ptsr_pkg::ID_W-1:0]     w_task_id;
    logic [ptsr_pkg::VAL_W-1:0]    w_value;
    logic [ptsr_pkg::VAL_W-1:0]    w_elapsed;
    logic [ptsr_pkg::VAL_W-1:0]    w_overhead;
    logic [ptsr_pkg::ID_EXT_W-1:0] w_id_ext;
    logic                          w_id_ok;
    logic [IDX_W-1:0]              w_wr_idx;
    logic                          w_accept;

    assign w_task_id  = s_axis_tdata[2:0];
    assign w_value    = s_axis_tdata[18:3];
    assign w_elapsed  = s_axis_tdata[34:19];
    assign w_overhead = s_axis_tdata[50:35];
    assign w_mode     = s_axis_tuser;
    assign w_id_ext   = ptsr_pkg::ID_EXT_W'(w_task_id);
    assign w_id_ok    = w_id_ext < ptsr_pkg::ID_EXT_W'(NUM_TASKS);
    assign w_wr_idx   = w_id_ext[IDX_W-1:0];
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    // read port of the table at the walk index
    logic [IDX_W-1:0]            w_rd_idx;
    logic signed [CD_W-1:0]      w_cd;
    logic                        w_ev;
    logic [ptsr_pkg::BYTE_W-1:0] w_lat;

    assign w_rd_idx = r_idx[IDX_W-1:0];
    assign w_cd     = r_cd[w_rd_idx];
    assign w_ev     = r_event[w_rd_idx] != '0;
    assign w_lat    = r_latency[w_rd_idx];

    // shared 33-bit subtractor: countdown minus elapsed while ageing,
    // nearest minus overhead when finishing
    logic signed [CD_W:0]        w_sub_a, w_sub_b, w_sub_y;
    logic signed [CD_W-1:0]      w_aged;
    logic [ptsr_pkg::VAL_W-1:0]  w_sub_rhs;

    assign w_sub_rhs = (r_state == ptsr_pkg::ST_FINISH) ? r_ovh : r_elap;
    assign w_sub_a   = (r_state == ptsr_pkg::ST_FINISH) ? {r_near[CD_W-1], r_near}
                                                        : {w_cd[CD_W-1], w_cd};
    assign w_sub_b   = $signed({{(CD_W+1-ptsr_pkg::VAL_W){1'b0}}, w_sub_rhs});
    assign w_sub_y   = w_sub_a - w_sub_b;
    // result below the signed minimum shows as a sign/overflow mismatch
    assign w_aged    = (w_sub_y[CD_W] != w_sub_y[CD_W-1]) ? ptsr_pkg::CD_MIN
                                                          : w_sub_y[CD_W-1:0];

    // takeover test against the reserve of the selected task
    logic [CD_W-1:0] w_res_clk;
    logic            w_take;

    assign w_res_clk = CD_W'(r_res) << TICK_SHIFT;
    assign w_take    = w_ev && ((w_lat < r_res) || (w_cd < $signed(w_res_clk)));

    // walk bounds
    logic w_age_last;
    logic w_chk_skip;
    logic w_chk_last;

    assign w_age_last = r_idx == CNT_W'(NUM_TASKS - 1);
    assign w_chk_skip = !r_found || (r_sel == '0);
    assign w_chk_last = (r_idx + CNT_W'(1)) == CNT_W'(r_sel);

    // ---------------------------------------------------------------
    // sequencer next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptsr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_mode == ptsr_pkg::MODE_SCHEDULE) ? ptsr_pkg::ST_AGE
                                                                  : ptsr_pkg::ST_OUT;
                end
            end
            ptsr_pkg::ST_AGE: begin
                if (w_age_last) begin
                    n_state = ptsr_pkg::ST_CHECK;
                end
            end
            ptsr_pkg::ST_CHECK: begin
                if (w_chk_skip || w_take || w_chk_last) begin
                    n_state = ptsr_pkg::ST_FINISH;
                end
            end
            ptsr_pkg::ST_FINISH: begin
                n_state = ptsr_pkg::ST_OUT;
            end
            ptsr_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ptsr_pkg::ST_IDLE;
                end
            end
            default: n_state = ptsr_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer outputs
    // ---------------------------------------------------------------
    logic w_do_age;
    logic w_do_chk;
    logic w_do_fin;

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_do_age      = 1'b0;
        w_do_chk      = 1'b0;
        w_do_fin      = 1'b0;
        unique case (r_state)
            ptsr_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            ptsr_pkg::ST_AGE:    w_do_age      = 1'b1;
            ptsr_pkg::ST_CHECK:  w_do_chk      = !w_chk_skip;
            ptsr_pkg::ST_FINISH: w_do_fin      = 1'b1;
            ptsr_pkg::ST_OUT:    m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptsr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // task table: writes at accept, countdown write-back while ageing
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_event[i]   <= '0;
                r_reserve[i] <= '0;
                r_latency[i] <= '0;
                r_cd[i]      <= '0;
            end
        end else if (w_accept && w_id_ok) begin
            case (w_mode)
                ptsr_pkg::MODE_SET_EVENT:   r_event[w_wr_idx]   <= w_value[7:0];
                ptsr_pkg::MODE_SET_RESERVE: r_reserve[w_wr_idx] <= w_value[7:0];
                ptsr_pkg::MODE_SET_LATENCY: r_latency[w_wr_idx] <= w_value[7:0];
                ptsr_pkg::MODE_SET_TICKS:   r_cd[w_wr_idx]      <= CD_W'(w_value) << TICK_SHIFT;
                ptsr_pkg::MODE_SYNC:        r_cd[w_wr_idx]      <= '0;
                default: ;
            endcase
        end else if (w_do_age) begin
            r_cd[w_rd_idx] <= w_aged;
        end
    end

    // ---------------------------------------------------------------
    // walk registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_sel   <= '0;
        end else if (w_accept) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_sel   <= '0;
        end else if (w_do_age) begin
            // first expired active task on the upward walk has top priority
            if (w_ev && (w_aged <= 0) && !r_found) begin
                r_found <= 1'b1;
                r_sel   <= w_rd_idx;
            end
            r_idx <= w_age_last ? '0 : r_idx + CNT_W'(1);
        end else if (w_do_chk) begin
            if (w_take) begin
                r_sel <= w_rd_idx;
            end
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // payload registers of the pass
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_near <= ptsr_pkg::WAKE_LIMIT;
            r_elap <= w_elapsed;
            r_ovh  <= w_overhead;
        end else if (w_do_age) begin
            if (w_ev && (w_aged <= 0) && !r_found) begin
                r_res <= r_reserve[w_rd_idx];
            end
            if (w_ev && (w_aged < r_near)) begin
                r_near <= w_aged;
            end
        end else if (w_do_chk && w_take) begin
            r_near <= w_cd;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic [ptsr_pkg::ID_EXT_W-1:0] w_sel_ext;

    assign w_sel_ext = ptsr_pkg::ID_EXT_W'(r_sel);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            // write beats answer with an all-zero result
            r_out_sched <= 1'b0;
            r_out_sel   <= '0;
            r_out_np    <= 1'b0;
            r_out_wake  <= '0;
        end else if (w_do_fin) begin
            r_out_sched <= 1'b1;
            r_out_sel   <= w_sel_ext[ptsr_pkg::ID_W-1:0];
            r_out_np    <= !r_found;
            r_out_wake  <= (w_sub_y > 0) ? w_sub_y[ptsr_pkg::VAL_W-1:0] : '0;
        end
    end

    assign m_axis_tdata = {4'b0, r_out_wake, r_out_np, r_out_sel};
    assign m_axis_tuser = r_out_sched;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("write result is not all zero");

    a_none_sel0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[2:0] == '0))
        else $error("nothing pending but a task other than 0 selected");

    a_chk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_chk |-> (r_idx < CNT_W'(r_sel)))
        else $error("takeover walk passed the selected task");

    a_sel_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptsr_pkg::ST_AGE && r_found) |=> (r_sel == $past(r_sel)))
        else $error("selection changed after the first expired task");

endmodule
